### sv/hssd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hssd_pkg;

   localparam int DIGITS_DEFAULT = 4;

   localparam int START_TICKS = 3;
   localparam int STOP_TICKS  = 3;
   localparam int BYTE_TICKS  = 18;
   localparam int DATA_BITS   = 16;
   localparam int SUB_W       = $clog2(BYTE_TICKS);

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 3;

   localparam logic [CSR_INDEX_W-1:0] CSR_BRIGHTNESS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COLON_ON   = 2'd1;

   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_TICK = 1'b1;

   localparam logic [7:0] CMD_DATA   = 8'h40;
   localparam logic [7:0] CMD_ADDR   = 8'hC0;
   localparam logic [7:0] CMD_DISP   = 8'h88;
   localparam logic [7:0] COLON_BIT  = 8'h80;
   localparam logic [7:0] BRIGHT_MSK = 8'h07;

   typedef struct packed {
      logic        func;
      logic [15:0] value;
   } req_type;

   typedef struct packed {
      logic clk_level;
      logic dio_level;
      logic busy_res;
      logic load_rejected;
      logic frame_done;
   } rsp_type;

   typedef struct packed {
      logic [2:0] brightness;
      logic       colon_on;
   } cfg_type;

   typedef enum logic [1:0] {
      FR_CMD,
      FR_DATA,
      FR_CTRL
   } frame_type;

   typedef enum logic [1:0] {
      PH_START,
      PH_BYTE,
      PH_STOP
   } phase_type;

   function automatic logic [7:0] seg_encode(input logic [3:0] nib);
      logic [7:0] seg;
      case (nib)
         4'h0: seg = 8'h3F;
         4'h1: seg = 8'h06;
         4'h2: seg = 8'h5B;
         4'h3: seg = 8'h4F;
         4'h4: seg = 8'h66;
         4'h5: seg = 8'h6D;
         4'h6: seg = 8'h7D;
         4'h7: seg = 8'h07;
         4'h8: seg = 8'h7F;
         4'h9: seg = 8'h6F;
         4'hA: seg = 8'h77;
         4'hB: seg = 8'h7C;
         4'hC: seg = 8'h39;
         4'hD: seg = 8'h5E;
         4'hE: seg = 8'h79;
         default: seg = 8'h71;
      endcase
      return seg;
   endfunction

endpackage

`default_nettype wire

### sv/hex_seven_segment_serial_driver.sv
// Two-wire seven-segment display driver. A load beat (func 0) latches a
// 16-bit value shown as DIGITS hex digits; every tick beat (func 1) is one
// bit delay and returns the clock and data pin levels for that interval.
// One update takes 72 + 18*DIGITS ticks: command 0x40, address 0xC0 plus
// one segment byte per digit, then 0x88 | brightness, each framed by start
// and stop conditions, LSB first, with an unread acknowledge clock per byte.
// Loads during an update are dropped and flagged. Every beat gives exactly
// one response beat; one beat is taken per clock while responses are not
// stalled, and each passes the input register, then the response register.
// CSR writes (brightness, colon_on) must be made while no update runs.
`timescale 1ns / 1ps
`default_nettype none

module hex_seven_segment_serial_driver
   import hssd_pkg::*;
#(
   parameter int DIGITS = DIGITS_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire req_type                req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output rsp_type                     rsp_data,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   cfg_type cfg_ff, cfg_in;
   logic    stg_valid;
   logic    stg_ready;
   req_type stg_data;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_BRIGHTNESS: cfg_in.brightness = csr_data;
            CSR_COLON_ON:   cfg_in.colon_on   = csr_data[0];
            default:        cfg_in            = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.brightness <= 3'd7;
         cfg_ff.colon_on   <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   hssd_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .stg_valid (stg_valid),
      .stg_ready (stg_ready),
      .stg_data  (stg_data)
   );

   hssd_sequencer #(
      .DIGITS (DIGITS)
   ) u_sequencer (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .stg_valid (stg_valid),
      .stg_ready (stg_ready),
      .stg_data  (stg_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

### sv/hssd_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module hssd_in_stage
   import hssd_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         stg_valid,
   input  wire logic    stg_ready,
   output req_type      stg_data
);

   logic    valid_ff;
   logic    valid_in;
   req_type data_ff;

   assign req_ready = !valid_ff || stg_ready;
   assign stg_valid = valid_ff;
   assign stg_data  = data_ff;

   always_comb begin
      valid_in = valid_ff;
      if (req_ready) begin
         valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         data_ff <= req_data;
      end
   end

endmodule

`default_nettype wire

### sv/hssd_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none

module hssd_sequencer
   import hssd_pkg::*;
#(
   parameter int DIGITS = DIGITS_DEFAULT
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cfg_type cfg,
   input  wire logic    stg_valid,
   output logic         stg_ready,
   input  wire req_type stg_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   localparam int BYTE_W = $clog2(DIGITS + 1);
   localparam int EXT_W  = 4 * DIGITS + DATA_BITS;
   localparam logic [BYTE_W-1:0] LAST_DIGIT = BYTE_W'(DIGITS);

   logic                busy_ff, busy_in;
   frame_type           frame_ff, frame_in;
   phase_type           phase_ff, phase_in;
   logic [SUB_W-1:0]    sub_ff, sub_in;
   logic [BYTE_W-1:0]   byte_ff, byte_in;
   logic [7:0]          shift_ff, shift_in;
   logic [15:0]         held_ff, held_in;
   logic                clk_pin_ff, clk_pin_in;
   logic                dio_pin_ff, dio_pin_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   logic                fire;
   logic [EXT_W-1:0]    held_ext;
   logic [BYTE_W-1:0]   nib_idx;
   logic [3:0]          nib;
   logic [7:0]          new_byte;
   logic [7:0]          cur_byte;
   logic                last_byte;

   assign stg_ready = !rsp_valid_ff || rsp_ready;
   assign fire      = stg_valid && stg_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // hex digit for the segment byte at the current position
   assign held_ext = EXT_W'(held_ff);
   assign nib_idx  = LAST_DIGIT - byte_ff;
   assign nib      = held_ext[4 * nib_idx +: 4];

   always_comb begin
      case (frame_ff)
         FR_CMD:  new_byte = CMD_DATA;
         FR_CTRL: new_byte = CMD_DISP | ({5'd0, cfg.brightness} & BRIGHT_MSK);
         FR_DATA: begin
            if (byte_ff == '0) begin
               new_byte = CMD_ADDR;
            end else begin
               new_byte = seg_encode(nib) | (cfg.colon_on ? COLON_BIT : 8'h00);
            end
         end
         default: new_byte = CMD_DATA;
      endcase
   end

   assign cur_byte  = (sub_ff == '0) ? new_byte : shift_ff;
   assign last_byte = (frame_ff == FR_DATA) ? (byte_ff == LAST_DIGIT) : (byte_ff == '0);

   always_comb begin
      busy_in      = busy_ff;
      frame_in     = frame_ff;
      phase_in     = phase_ff;
      sub_in       = sub_ff;
      byte_in      = byte_ff;
      shift_in     = shift_ff;
      held_in      = held_ff;
      clk_pin_in   = clk_pin_ff;
      dio_pin_in   = dio_pin_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;

      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (fire) begin
         rsp_valid_in         = 1'b1;
         rsp_in.load_rejected = 1'b0;
         rsp_in.frame_done    = 1'b0;
         if (stg_data.func == FUNC_LOAD) begin
            if (busy_ff) begin
               rsp_in.load_rejected = 1'b1;
            end else begin
               held_in  = stg_data.value;
               busy_in  = 1'b1;
               frame_in = FR_CMD;
               phase_in = PH_START;
               sub_in   = '0;
               byte_in  = '0;
            end
            rsp_in.busy_res = 1'b1;
         end else if (!busy_ff) begin
            rsp_in.busy_res = 1'b0;
         end else begin
            rsp_in.busy_res = 1'b1;
            sub_in          = sub_ff + SUB_W'(1);
            unique case (phase_ff)
               PH_START: begin
                  clk_pin_in = (sub_ff < SUB_W'(2));
                  dio_pin_in = (sub_ff == '0);
                  if (sub_ff == SUB_W'(START_TICKS - 1)) begin
                     phase_in = PH_BYTE;
                     sub_in   = '0;
                     byte_in  = '0;
                  end
               end
               PH_BYTE: begin
                  shift_in = cur_byte;
                  if (sub_ff < SUB_W'(16)) begin
                     clk_pin_in = sub_ff[0];
                     dio_pin_in = cur_byte[sub_ff[3:1]];
                  end else begin
                     clk_pin_in = (sub_ff == SUB_W'(BYTE_TICKS - 1));
                     dio_pin_in = cur_byte[7];
                  end
                  if (sub_ff == SUB_W'(BYTE_TICKS - 1)) begin
                     sub_in = '0;
                     if (last_byte) begin
                        phase_in = PH_STOP;
                     end else begin
                        byte_in = byte_ff + BYTE_W'(1);
                     end
                  end
               end
               PH_STOP: begin
                  clk_pin_in = (sub_ff != '0);
                  dio_pin_in = (sub_ff == SUB_W'(2));
                  if (sub_ff == SUB_W'(STOP_TICKS - 1)) begin
                     sub_in   = '0;
                     phase_in = PH_START;
                     unique case (frame_ff)
                        FR_CMD:  frame_in = FR_DATA;
                        FR_DATA: frame_in = FR_CTRL;
                        default: begin
                           frame_in          = FR_CMD;
                           busy_in           = 1'b0;
                           rsp_in.frame_done = 1'b1;
                        end
                     endcase
                  end
               end
               default: begin
                  phase_in = PH_START;
                  sub_in   = '0;
               end
            endcase
         end
         rsp_in.clk_level = clk_pin_in;
         rsp_in.dio_level = dio_pin_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         frame_ff     <= FR_CMD;
         phase_ff     <= PH_START;
         sub_ff       <= '0;
         byte_ff      <= '0;
         clk_pin_ff   <= 1'b1;
         dio_pin_ff   <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         frame_ff     <= frame_in;
         phase_ff     <= phase_in;
         sub_ff       <= sub_in;
         byte_ff      <= byte_in;
         clk_pin_ff   <= clk_pin_in;
         dio_pin_ff   <= dio_pin_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      held_ff  <= held_in;
      rsp_ff   <= rsp_in;
   end

endmodule

`default_nettype wire

### sv/hssd_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module hssd_checker
   import hssd_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response beat changed while stalled");

   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.frame_done |-> rsp_data.busy_res
         && !rsp_data.load_rejected && rsp_data.clk_level && rsp_data.dio_level)
      else $error("final tick without busy or with bus not released");

   a_reject_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.load_rejected |-> rsp_data.busy_res)
      else $error("load rejected while idle");

   a_idle_high: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.busy_res |-> rsp_data.clk_level && rsp_data.dio_level)
      else $error("bus not idle high while idle");

endmodule

bind hex_seven_segment_serial_driver hssd_checker u_hssd_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire

### sim/hex_seven_segment_serial_driver_test.sv
`timescale 1ns / 1ps

module hex_seven_segment_serial_driver_test;
   import hssd_pkg::*;

   localparam int DIGITS      = DIGITS_DEFAULT;
   localparam int LATENCY     = 2;
   localparam int CYCLE_LIMIT = 300000;
   localparam int HOLD_CYCLES = 300;
   localparam int PHASE_BEATS = 145;

   localparam int CMD_LEN  = START_TICKS + BYTE_TICKS + STOP_TICKS;
   localparam int DATA_LEN = START_TICKS + BYTE_TICKS * (DIGITS + 1) + STOP_TICKS;
   localparam int CTRL_LEN = START_TICKS + BYTE_TICKS + STOP_TICKS;
   localparam int SEQ_LEN  = CMD_LEN + DATA_LEN + CTRL_LEN;

   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_3 = 2'd3;

   localparam logic [7:0] SEGMENTS [16] = '{
      8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
      8'h7F, 8'h6F, 8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71
   };

   class pin_level_scoreboard;
      logic [2:0]  brightness;
      logic        colon_on;
      logic        busy;
      int          position;
      logic [7:0]  shift_byte;
      logic [15:0] held_value;
      logic        clk_pin;
      logic        dio_pin;
      rsp_type     pending_levels[$];
      int          errors;

      function new();
         brightness = 3'd7;
         colon_on   = 1'b0;
         busy       = 1'b0;
         position   = 0;
         shift_byte = 8'h00;
         held_value = 16'h0000;
         clk_pin    = 1'b1;
         dio_pin    = 1'b1;
         errors     = 0;
      endfunction

      function void set_register(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         if (idx == CSR_BRIGHTNESS) begin
            brightness = data;
         end else if (idx == CSR_COLON_ON) begin
            colon_on = data[0];
         end
      endfunction

      function logic [7:0] byte_at(frame_type fr, int k);
         logic [3:0] nib;
         case (fr)
            FR_CMD: begin
               return CMD_DATA;
            end
            FR_CTRL: begin
               return CMD_DISP | (8'(brightness) & BRIGHT_MSK);
            end
            default: begin
               if (k == 0) return CMD_ADDR;
               nib = 4'(held_value >> (4 * (DIGITS - k)));
               return SEGMENTS[nib] | (colon_on ? COLON_BIT : 8'h00);
            end
         endcase
      endfunction

      function void transfer_levels(frame_type fr, int o, int nbytes,
                                    output logic c, output logic d);
         int k;
         int b;
         if (o < START_TICKS) begin
            c = (o < 2);
            d = (o == 0);
         end else if (o - START_TICKS < BYTE_TICKS * nbytes) begin
            k = (o - START_TICKS) / BYTE_TICKS;
            b = (o - START_TICKS) % BYTE_TICKS;
            if (b == 0) shift_byte = byte_at(fr, k);
            if (b < 16) begin
               c = b[0];
               d = shift_byte[b >> 1];
            end else begin
               c = (b != 16);
               d = shift_byte[7];
            end
         end else begin
            o = o - START_TICKS - BYTE_TICKS * nbytes;
            c = (o != 0);
            d = (o == 2);
         end
      endfunction

      function void note_request(req_type beat);
         rsp_type want;
         logic    c;
         logic    d;
         want = '0;
         if (beat.func == FUNC_LOAD) begin
            if (busy) begin
               want.load_rejected = 1'b1;
            end else begin
               held_value = beat.value;
               busy       = 1'b1;
               position   = 0;
            end
            want.busy_res = busy;
         end else if (busy) begin
            if (position < CMD_LEN)
               transfer_levels(FR_CMD, position, 1, c, d);
            else if (position < CMD_LEN + DATA_LEN)
               transfer_levels(FR_DATA, position - CMD_LEN, DIGITS + 1, c, d);
            else
               transfer_levels(FR_CTRL, position - CMD_LEN - DATA_LEN, 1, c, d);
            clk_pin       = c;
            dio_pin       = d;
            want.busy_res = 1'b1;
            if (position + 1 >= SEQ_LEN) begin
               want.frame_done = 1'b1;
               busy            = 1'b0;
               position        = 0;
            end else begin
               position++;
            end
         end
         want.clk_level = clk_pin;
         want.dio_level = dio_pin;
         pending_levels.push_back(want);
      endfunction

      function void flag_error(string what, rsp_type want, rsp_type got);
         errors++;
         if (errors <= 10)
            $display("mismatch on %0s: expected %b actual %b (clk dio busy rej done)",
                     what, want, got);
      endfunction

      function void check_levels(rsp_type got);
         rsp_type want;
         if (pending_levels.size() == 0) begin
            flag_error("unexpected beat", '0, got);
            return;
         end
         want = pending_levels.pop_front();
         if (got.clk_level !== want.clk_level) flag_error("clk_level", want, got);
         if (got.dio_level !== want.dio_level) flag_error("dio_level", want, got);
         if (got.busy_res !== want.busy_res) flag_error("busy_res", want, got);
         if (got.load_rejected !== want.load_rejected) flag_error("load_rejected", want, got);
         if (got.frame_done !== want.frame_done) flag_error("frame_done", want, got);
      endfunction
   endclass

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_type                req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data  = '0;

   pin_level_scoreboard sb;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_requests = 0;
   int hold_seen     = 0;
   int hold_left     = 0;
   int cycles        = 0;

   hex_seven_segment_serial_driver uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("hex_seven_segment_serial_driver_test: errors");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_levels(rsp_data);
      if (hold_seen != hold_requests) begin
         hold_seen = hold_requests;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic send_beat(input logic func, input logic [15:0] value);
      req_type beat;
      beat.func  = func;
      beat.value = value;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (!req_ready);
      sb.note_request(beat);
   endtask

   task automatic wait_drained(input int extra);
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending_levels.size() != 0);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      sb.set_register(idx, data);
   endtask

   task automatic run_phase(input int count, input bit long_hold, input bit mid_pause);
      int          n;
      logic        func;
      logic [15:0] value;
      int          pick;
      n = 0;
      while (n < count || sb.busy) begin
         if (long_hold && n == 20) hold_requests++;
         if (mid_pause && n == count / 2) wait_drained(0);
         if (!sb.busy)
            func = ($urandom_range(99) < 70) ? FUNC_LOAD : FUNC_TICK;
         else
            func = ($urandom_range(99) < 4) ? FUNC_LOAD : FUNC_TICK;
         pick = $urandom_range(9);
         value = (pick == 0) ? 16'h0000 : (pick == 1) ? 16'hFFFF : 16'($urandom);
         if ((func == FUNC_LOAD) != sb.busy) n++;
         send_beat(func, value);
      end
   endtask

   initial begin
      int ph;
      sb = new();
      send_idle_pct = 30;
      recv_idle_pct = 76;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // idle ticks, accepted and rejected loads, start of the first transfer
      send_beat(FUNC_TICK, 16'hFFFF);
      send_beat(FUNC_TICK, 16'h0000);
      send_beat(FUNC_LOAD, 16'hFFFF);
      send_beat(FUNC_LOAD, 16'h0000);
      repeat (18) send_beat(FUNC_TICK, 16'h0000);
      send_beat(FUNC_LOAD, 16'h1234);
      repeat (2) send_beat(FUNC_TICK, 16'hFFFF);

      for (ph = 0; ph < 6; ph++) begin
         if (ph < 2) begin
            send_idle_pct = 30;
            recv_idle_pct = 76;
         end else if (ph < 4) begin
            send_idle_pct = 76;
            recv_idle_pct = 30;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         run_phase((ph == 1 || ph == 3) ? 2 * PHASE_BEATS : PHASE_BEATS, ph == 4, ph == 3);
         wait_drained(LATENCY + 4);
         if (ph < 5) begin
            case (ph)
               0: begin
                  write_csr(CSR_BRIGHTNESS, 3'd0);
                  write_csr(CSR_COLON_ON, 3'd1);
                  write_csr(CSR_SPARE_2, 3'd5);
                  write_csr(CSR_SPARE_3, 3'd2);
               end
               1: begin
                  write_csr(CSR_BRIGHTNESS, 3'd7);
                  write_csr(CSR_COLON_ON, 3'd0);
               end
               default: begin
                  write_csr(CSR_BRIGHTNESS, 3'($urandom_range(7)));
                  write_csr(CSR_COLON_ON, 3'($urandom_range(7)));
               end
            endcase
            csr_valid <= 1'b0;
            @(posedge clock);
         end
      end

      if (sb.errors == 0 && sb.pending_levels.size() == 0) begin
         $display("hex_seven_segment_serial_driver_test: clean");
      end else begin
         $display("hex_seven_segment_serial_driver_test: errors");
      end
      $finish;
   end

endmodule

### sim.f
sv/hssd_pkg.sv
sv/hssd_in_stage.sv
sv/hssd_sequencer.sv
sv/hex_seven_segment_serial_driver.sv
sv/hssd_checker.sv
sim/hex_seven_segment_serial_driver_test.sv
